// File: rtl/caldate_pkg.sv
`timescale 1ns / 1ps

package caldate_pkg;

   localparam int YearBits = 16;

   // operation codes
   localparam logic [2:0] OpNextDay  = 3'd0;
   localparam logic [2:0] OpPrevDay  = 3'd1;
   localparam logic [2:0] OpSetDay   = 3'd2;
   localparam logic [2:0] OpSetMonth = 3'd3;
   localparam logic [2:0] OpSetYear  = 3'd4;
   localparam logic [2:0] OpLoadDate = 3'd5;

   localparam logic [3:0] MonthFeb  = 4'd2;
   localparam logic [3:0] MonthApr  = 4'd4;
   localparam logic [3:0] MonthJun  = 4'd6;
   localparam logic [3:0] MonthSep  = 4'd9;
   localparam logic [3:0] MonthNov  = 4'd11;
   localparam logic [3:0] MonthDec  = 4'd12;
   localparam logic [3:0] MonthJan  = 4'd1;

   localparam logic [4:0] DayFirst  = 5'd1;
   localparam logic [4:0] DayLast   = 5'd31;

   localparam logic [YearBits-1:0] YearMax = {YearBits{1'b1}};

   // inverse of 25 modulo 2^32, by newton steps at elaboration
   function automatic logic [31:0] inv25_calc();
      logic [31:0] x;
      x = 32'd1;
      for (int i = 0; i < 5; i++) begin
         x = x * (32'd2 - 32'd25 * x);
      end
      return x;
   endfunction

   localparam logic [YearBits-1:0] Inv25 = YearBits'(inv25_calc());
   localparam logic [YearBits-1:0] Div25Limit =
      YearBits'(((64'd1 << YearBits) - 64'd1) / 64'd25);

   // y divisible by 25 iff y * inv(25) wraps to at most (2^n - 1) / 25
   function automatic logic year_leap(logic [YearBits-1:0] y);
      logic [YearBits-1:0] prod;
      prod = y * Inv25;
      return (y[1:0] == 2'b00) && ((y[3:0] == 4'b0000) || (prod > Div25Limit));
   endfunction

   function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
      logic [4:0] len;
      case (m) inside
         MonthFeb: len = leap ? 5'd29 : 5'd28;
         MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic day_month_ok(logic [4:0] d, logic [3:0] m, logic leap);
      return (m >= MonthJan) && (m <= MonthDec) && (d != 5'd0) && (d <= month_len(m, leap));
   endfunction

   localparam logic [4:0] ResetDay = DayFirst;
   localparam logic [3:0] ResetMonth = MonthJan;
   localparam logic [YearBits-1:0] ResetYear = YearBits'(2023);
   localparam logic ResetLeap = year_leap(ResetYear);

   typedef struct packed {
      logic [4:0]          day;
      logic [3:0]          month;
      logic [YearBits-1:0] year;
      logic                leap;
   } date_type;

   typedef struct packed {
      logic [2:0]          op;
      logic [4:0]          new_day;
      logic [3:0]          new_month;
      logic [YearBits-1:0] new_year;
   } cmd_type;

endpackage

// File: rtl/caldate_req_if.sv
`timescale 1ns / 1ps

interface caldate_req_if;
   import caldate_pkg::*;

   logic                valid;
   logic                ready;
   logic [2:0]          op;
   logic [4:0]          new_day;
   logic [3:0]          new_month;
   logic [YearBits-1:0] new_year;

   modport source (output valid, output op, output new_day, output new_month,
                   output new_year, input ready);
   modport sink (input valid, input op, input new_day, input new_month,
                 input new_year, output ready);
endinterface

// File: rtl/caldate_rsp_if.sv
`timescale 1ns / 1ps

interface caldate_rsp_if;
   import caldate_pkg::*;

   logic                valid;
   logic                ready;
   logic [4:0]          day_out;
   logic [3:0]          month_out;
   logic [YearBits-1:0] year_out;
   logic                leap_year;
   logic                accepted;

   modport source (output valid, output day_out, output month_out, output year_out,
                   output leap_year, output accepted, input ready);
   modport sink (input valid, input day_out, input month_out, input year_out,
                 input leap_year, input accepted, output ready);
endinterface

// File: rtl/caldate_step.sv
`timescale 1ns / 1ps

module caldate_step
   import caldate_pkg::*;
(
   input  date_type cur,
   input  cmd_type  cmd,
   output date_type nxt,
   output logic     accepted
);

   logic [4:0]          cur_len;
   logic [4:0]          prev_len;
   logic [3:0]          prev_month;
   logic [YearBits-1:0] year_succ;
   logic [YearBits-1:0] year_pred;
   logic                leap_succ;
   logic                leap_pred;
   logic                leap_new;

   always_comb begin
      prev_month = cur.month - 4'd1;
      cur_len    = month_len(cur.month, cur.leap);
      prev_len   = month_len(prev_month, cur.leap);
      year_succ  = cur.year + YearBits'(1);
      year_pred  = cur.year - YearBits'(1);
      // three leap tests side by side, none feeds another
      leap_succ  = year_leap(year_succ);
      leap_pred  = year_leap(year_pred);
      leap_new   = year_leap(cmd.new_year);
   end

   always_comb begin
      nxt      = cur;
      accepted = 1'b0;
      unique case (cmd.op)
         OpNextDay: begin
            if (cur.day < cur_len) begin
               nxt.day  = cur.day + 5'd1;
               accepted = 1'b1;
            end else if (cur.month < MonthDec) begin
               nxt.day   = DayFirst;
               nxt.month = cur.month + 4'd1;
               accepted  = 1'b1;
            end else if (cur.year != YearMax) begin
               nxt.day   = DayFirst;
               nxt.month = MonthJan;
               nxt.year  = year_succ;
               nxt.leap  = leap_succ;
               accepted  = 1'b1;
            end
         end
         OpPrevDay: begin
            if (cur.day > DayFirst) begin
               nxt.day  = cur.day - 5'd1;
               accepted = 1'b1;
            end else if (cur.month > MonthJan) begin
               nxt.month = prev_month;
               nxt.day   = prev_len;
               accepted  = 1'b1;
            end else if (cur.year > YearBits'(1)) begin
               nxt.day   = DayLast;
               nxt.month = MonthDec;
               nxt.year  = year_pred;
               nxt.leap  = leap_pred;
               accepted  = 1'b1;
            end
         end
         OpSetDay: begin
            if (day_month_ok(cmd.new_day, cur.month, cur.leap)) begin
               nxt.day  = cmd.new_day;
               accepted = 1'b1;
            end
         end
         OpSetMonth: begin
            if (day_month_ok(cur.day, cmd.new_month, cur.leap)) begin
               nxt.month = cmd.new_month;
               accepted  = 1'b1;
            end
         end
         OpSetYear: begin
            if ((cmd.new_year != '0) && (cur.day <= month_len(cur.month, leap_new))) begin
               nxt.year = cmd.new_year;
               nxt.leap = leap_new;
               accepted = 1'b1;
            end
         end
         OpLoadDate: begin
            if ((cmd.new_year != '0) &&
                day_month_ok(cmd.new_day, cmd.new_month, leap_new)) begin
               nxt.day   = cmd.new_day;
               nxt.month = cmd.new_month;
               nxt.year  = cmd.new_year;
               nxt.leap  = leap_new;
               accepted  = 1'b1;
            end else begin
               nxt.day   = ResetDay;
               nxt.month = ResetMonth;
               nxt.year  = ResetYear;
               nxt.leap  = ResetLeap;
            end
         end
         default: begin
            // unused codes leave the date alone
            nxt      = cur;
            accepted = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/calendar_date_counter.sv
`timescale 1ns / 1ps
// channel  | dir | handshake          | payload
// req_ch   | in  | valid / ready      | op, new_day, new_month, new_year
// rsp_ch   | out | valid / ready      | day_out, month_out, year_out, leap_year, accepted
//
// one item per cycle unless rsp_ch stalls; items pass the input then the date register
// the step logic between the input register and the date register sets the clock
// reset (synchronous) empties both stages and loads 1/1/2023
// a stalled result holds the date register; the input register still takes one item

module calendar_date_counter
   import caldate_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   caldate_req_if.sink       req_ch,
   caldate_rsp_if.source     rsp_ch
);

   logic     in_valid_ff;
   logic     in_valid_in;
   cmd_type  cmd_ff;
   logic     out_valid_ff;
   logic     out_valid_in;
   date_type date_ff;
   date_type date_in;
   logic     accepted_ff;
   logic     step_accepted;
   logic     advance;
   logic     take;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take = req_ch.valid && req_ch.ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   caldate_step u_step (
      .cur      (date_ff),
      .cmd      (cmd_ff),
      .nxt      (date_in),
      .accepted (step_accepted)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         date_ff.day   <= ResetDay;
         date_ff.month <= ResetMonth;
         date_ff.year  <= ResetYear;
         date_ff.leap  <= ResetLeap;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            date_ff <= date_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff.op        <= req_ch.op;
         cmd_ff.new_day   <= req_ch.new_day;
         cmd_ff.new_month <= req_ch.new_month;
         cmd_ff.new_year  <= req_ch.new_year;
      end
      if (advance) begin
         accepted_ff <= step_accepted;
      end
   end

   // the date register doubles as the result register
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.day_out   = date_ff.day;
   assign rsp_ch.month_out = date_ff.month;
   assign rsp_ch.year_out  = date_ff.year;
   assign rsp_ch.leap_year = date_ff.leap;
   assign rsp_ch.accepted  = accepted_ff;

endmodule

// File: rtl/caldate_checker.sv
`timescale 1ns / 1ps

module caldate_assertions
   import caldate_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [4:0]          day_out,
   input logic [3:0]          month_out,
   input logic [YearBits-1:0] year_out,
   input logic                leap_year,
   input logic                accepted
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({day_out, month_out, year_out, leap_year, accepted}))
      else $error("stalled item changed");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (month_out >= MonthJan) && (month_out <= MonthDec) &&
         (day_out != 5'd0) && (year_out != '0))
      else $error("date out of range");

   a_leap_day: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (month_out == MonthFeb) && (day_out > 5'd28) |->
         leap_year && (day_out == 5'd29))
      else $error("february day past its length");

   a_short_month: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((month_out == MonthApr) || (month_out == MonthJun) ||
         (month_out == MonthSep) || (month_out == MonthNov)) |-> (day_out <= 5'd30))
      else $error("day 31 in a 30 day month");

endmodule

bind calendar_date_counter caldate_assertions u_caldate_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .day_out   (rsp_ch.day_out),
   .month_out (rsp_ch.month_out),
   .year_out  (rsp_ch.year_out),
   .leap_year (rsp_ch.leap_year),
   .accepted  (rsp_ch.accepted)
);
